### rtl/lrbe_pkg.sv
// lrbe_pkg: shared types and constants for the log ring buffer engine
// no dependencies; imported by log_ring_buffer_engine
`timescale 1ns / 1ps

package lrbe_pkg;

  // width of a log sequence number; all lsn math wraps here
  localparam int unsigned LSN_W = 48;

  // fixed field widths of the command and result ports
  localparam int unsigned SIZE_W  = 17;
  localparam int unsigned OFFS_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_W   = 5;

  // io unit log2 after reset
  localparam logic [CFG_W-1:0] IO_UNIT_LOG2_RST = 5'd9;

  // command codes
  typedef enum logic [1:0] {
    ACT_RESERVE = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_FLUSH   = 2'd2,
    ACT_READ    = 2'd3
  } action_e;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RSV  = 6'b000010,
    ST_RD   = 6'b000100,
    ST_FLA  = 6'b001000,
    ST_FLB  = 6'b010000,
    ST_FLC  = 6'b100000
  } state_e;

endpackage

### rtl/log_ring_buffer_engine.sv
// log_ring_buffer_engine: lsn-addressed byte ring buffer with span reserve and flush
// depends on lrbe_pkg and lrbe_ram
`timescale 1ns / 1ps

// Usage
//   Commands enter on start_i with the command fields; a beat is taken at a
//   clock edge where start_i is high and busy_o is low. Results leave on the
//   result ports for one cycle, flagged by valid_o; last_o marks the final
//   result of a command. The receiver cannot stall, so results never wait.
//   io_unit_log2 is written through cfg_we_i / cfg_wdata_i; the user does so only
//   while idle, which the block itself does not enforce.
// Sequence per command (states from accept until the next command can enter)
//   write byte: stays idle, no result; the byte store takes it at the accept edge
//   read byte : ST_RD, result registered from the store's registered read
//   reserve   : ST_RSV, one 48-bit add at accept, the space check the next cycle
//   flush     : ST_FLA, ST_FLB, plus ST_FLC with two results on a buffer-end wrap
//   Results are registered; the store's single port and flush pipeline set the rate.
// Reset
//   Head and persisted lsn clear to zero, io_unit_log2 returns to 9. The byte
//   store is not cleared; reading a never-written byte returns garbage.

module log_ring_buffer_engine
  import lrbe_pkg::*;
#(
  parameter int unsigned BUF_BYTES = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command channel
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           action_i,
  input  logic [SIZE_W-1:0]    reserve_size_i,
  input  logic [LSN_W-1:0]     byte_lsn_i,
  input  logic [BYTE_W-1:0]    data_byte_i,
  input  logic [LSN_W-1:0]     flush_target_i,
  input  logic [OFFS_W-1:0]    read_offset_i,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // result channel
  output logic                 valid_o,
  output logic [LSN_W-1:0]     lsn_out_o,
  output logic                 status_o,
  output logic [OFFS_W-1:0]    seg_offset_o,
  output logic [SIZE_W-1:0]    seg_length_o,
  output logic [BYTE_W-1:0]    read_data_o,
  output logic                 last_o
);

  localparam int unsigned AW = $clog2(BUF_BYTES);
  localparam int unsigned PW = AW + 1;
  localparam logic [PW-1:0]    BUF_P = PW'(BUF_BYTES);
  localparam logic [LSN_W-1:0] BUF_L = LSN_W'(BUF_BYTES);

  state_e             state_q, state_d;
  logic [LSN_W-1:0]   head_q, head_d;
  logic [LSN_W-1:0]   pers_q, pers_d;
  logic [CFG_W-1:0]   io_log2_q;

  // per-command working registers
  logic [LSN_W-1:0]   end_q, end_d;
  logic [LSN_W-1:0]   pend_raw_q, pend_raw_d;
  logic [PW-1:0]      pend_q, pend_d;
  logic               pzero_q, pzero_d;
  logic [PW-1:0]      second_q, second_d;

  // result registers
  logic               res_valid_q, res_valid_d;
  logic [LSN_W-1:0]   res_lsn_q, res_lsn_d;
  logic               res_status_q, res_status_d;
  logic [OFFS_W-1:0]  res_off_q, res_off_d;
  logic [SIZE_W-1:0]  res_len_q, res_len_d;
  logic [BYTE_W-1:0]  res_rd_q, res_rd_d;
  logic               res_last_q, res_last_d;

  // byte store port
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [BYTE_W-1:0]  ram_rdata;

  logic               accept;
  logic [LSN_W-1:0]   ahead;
  logic [PW-1:0]      pend_sat;
  logic [PW-1:0]      unit_w;
  logic               unit_big;
  logic               round_en;
  logic [PW-1:0]      pend_round;
  logic [AW-1:0]      start_off;
  logic [PW-1:0]      span_end;
  logic               wrap;
  logic [PW-1:0]      first_len;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  // byte store: writes and read requests issue at the accept edge
  assign ram_we   = accept && (action_i == ACT_WRITE);
  assign ram_addr = (action_i == ACT_WRITE) ? byte_lsn_i[AW-1:0] : AW'(read_offset_i);

  lrbe_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (data_byte_i),
    .rdata_o (ram_rdata)
  );

  // reserve space check against the persisted lsn
  assign ahead = end_q - pers_q;

  // flush sizing: saturate at the buffer size, round down to whole units when above one unit
  assign pend_sat   = (pend_raw_q > BUF_L) ? BUF_P : PW'(pend_raw_q);
  assign unit_w     = PW'(1) << io_log2_q;
  assign unit_big   = (io_log2_q >= CFG_W'(PW));
  assign round_en   = !unit_big && (pend_sat > unit_w);
  assign pend_round = round_en ? (pend_sat & ~(unit_w - PW'(1))) : pend_sat;

  // flush segments: split where the span crosses the buffer end
  assign start_off = pers_q[AW-1:0];
  assign span_end  = {1'b0, start_off} + pend_q;
  assign wrap      = (span_end > BUF_P);
  assign first_len = BUF_P - {1'b0, start_off};

  // command sequencer
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    pers_d       = pers_q;
    end_d        = end_q;
    pend_raw_d   = pend_raw_q;
    pend_d       = pend_q;
    pzero_d      = pzero_q;
    second_d     = second_q;
    res_valid_d  = 1'b0;
    res_lsn_d    = '0;
    res_status_d = 1'b0;
    res_off_d    = '0;
    res_len_d    = '0;
    res_rd_d     = '0;
    res_last_d   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_RESERVE: begin
              end_d   = head_q + LSN_W'(reserve_size_i);
              state_d = ST_RSV;
            end
            ACT_FLUSH: begin
              pend_raw_d = flush_target_i - pers_q;
              state_d    = ST_FLA;
            end
            ACT_READ: begin
              state_d = ST_RD;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_RSV: begin
        res_valid_d = 1'b1;
        res_lsn_d   = head_q;
        res_last_d  = 1'b1;
        if (ahead >= BUF_L) begin
          res_status_d = 1'b1;
        end else begin
          head_d = end_q;
        end
        state_d = ST_IDLE;
      end
      ST_RD: begin
        res_valid_d = 1'b1;
        res_rd_d    = ram_rdata;
        res_last_d  = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_FLA: begin
        pzero_d = (pend_raw_q == '0);
        pend_d  = pend_round;
        state_d = ST_FLB;
      end
      ST_FLB: begin
        res_valid_d = 1'b1;
        if (pzero_q) begin
          res_lsn_d  = pers_q;
          res_last_d = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          pers_d    = pers_q + LSN_W'(pend_q);
          res_lsn_d = pers_q + LSN_W'(pend_q);
          res_off_d = OFFS_W'(start_off);
          if (wrap) begin
            res_len_d  = SIZE_W'(first_len);
            second_d   = pend_q - first_len;
            res_last_d = 1'b0;
            state_d    = ST_FLC;
          end else begin
            res_len_d  = SIZE_W'(pend_q);
            res_last_d = 1'b1;
            state_d    = ST_IDLE;
          end
        end
      end
      ST_FLC: begin
        res_valid_d = 1'b1;
        res_lsn_d   = pers_q;
        res_len_d   = SIZE_W'(second_q);
        res_last_d  = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state and lsn pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      pers_q      <= '0;
      io_log2_q   <= IO_UNIT_LOG2_RST;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      pers_q      <= pers_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        io_log2_q <= cfg_wdata_i;
      end
    end
  end

  // working and result payload registers
  always_ff @(posedge clk_i) begin
    end_q        <= end_d;
    pend_raw_q   <= pend_raw_d;
    pend_q       <= pend_d;
    pzero_q      <= pzero_d;
    second_q     <= second_d;
    res_lsn_q    <= res_lsn_d;
    res_status_q <= res_status_d;
    res_off_q    <= res_off_d;
    res_len_q    <= res_len_d;
    res_rd_q     <= res_rd_d;
    res_last_q   <= res_last_d;
  end

  assign valid_o      = res_valid_q;
  assign lsn_out_o    = res_lsn_q;
  assign status_o     = res_status_q;
  assign seg_offset_o = res_off_q;
  assign seg_length_o = res_len_q;
  assign read_data_o  = res_rd_q;
  assign last_o       = res_last_q;

  // a first flush segment is always followed by the closing one
  a_wrap_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> (valid_o && last_o))
    else $error("wrapped flush without its second segment");

  // a byte write accepted while idle produces no result beat
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (action_i == ACT_WRITE)) |=> !valid_o)
    else $error("result beat after a byte write");

  // a refused reservation carries no flush segment
  a_refuse_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o) |-> (seg_length_o == '0 && last_o))
    else $error("refused reservation with segment data");

  // a flush with a nonzero span advances the persisted lsn by that span
  a_pers_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLB && !pzero_q) |=> (pers_q == $past(pers_q) + LSN_W'($past(pend_q))))
    else $error("persisted lsn did not advance by the flushed span");

endmodule

### rtl/lrbe_ram.sv
// lrbe_ram: generic single-port ram with registered read data
// no dependencies; used for the byte store of log_ring_buffer_engine
`timescale 1ns / 1ps

module lrbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read of the same address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
